@@ sv/csbe_pkg.sv @@
package csbe_pkg;

   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_ASTERISK  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

   // beat position inside an octal escape
   typedef enum logic [1:0] {
      ESC_SLASH = 2'd0,
      ESC_HIGH  = 2'd1,
      ESC_MID   = 2'd2,
      ESC_LOW   = 2'd3
   } esc_pos_type;

endpackage

@@ sv/csbe_lexer.sv @@
module csbe_lexer
   import csbe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic [7:0] lex_byte,
   output logic       escape
);

   typedef enum logic [2:0] {
      MODE_CODE = 3'd0,
      MODE_STR  = 3'd1,
      MODE_MBC  = 3'd2,
      MODE_BLK  = 3'd3,
      MODE_MBE  = 3'd4,
      MODE_LINE = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      CLS_NL,
      CLS_DQ,
      CLS_SL,
      CLS_HI,
      CLS_AST,
      CLS_OTHER
   } class_type;

   mode_type  mode_ff;
   mode_type  mode_in;
   class_type cls;

   always_comb begin
      if (lex_byte == CHAR_ASTERISK) begin
         cls = CLS_AST;
      end else if (lex_byte == CHAR_QUOTE) begin
         cls = CLS_DQ;
      end else if (lex_byte == CHAR_SLASH) begin
         cls = CLS_SL;
      end else if (lex_byte == CHAR_NEWLINE) begin
         cls = CLS_NL;
      end else if (lex_byte[7]) begin
         cls = CLS_HI;
      end else begin
         cls = CLS_OTHER;
      end
   end

   always_comb begin
      escape  = 1'b0;
      mode_in = mode_ff;
      case (mode_ff)
         MODE_STR: begin
            escape  = (cls == CLS_HI);
            mode_in = (cls == CLS_DQ) ? MODE_CODE : MODE_STR;
         end
         MODE_MBC: begin
            case (cls)
               CLS_SL:  mode_in = MODE_LINE;
               CLS_AST: mode_in = MODE_BLK;
               default: mode_in = MODE_CODE;
            endcase
         end
         MODE_BLK: begin
            mode_in = (cls == CLS_AST) ? MODE_MBE : MODE_BLK;
         end
         MODE_MBE: begin
            mode_in = (cls == CLS_SL) ? MODE_CODE : MODE_BLK;
         end
         MODE_LINE: begin
            mode_in = (cls == CLS_NL) ? MODE_CODE : MODE_LINE;
         end
         default: begin
            // code mode, and the two unused codes
            escape = (cls == CLS_HI);
            case (cls)
               CLS_DQ:  mode_in = MODE_STR;
               CLS_SL:  mode_in = MODE_MBC;
               default: mode_in = MODE_CODE;
            endcase
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_CODE;
      end else if (advance) begin
         mode_ff <= mode_in;
      end
   end

endmodule

@@ sv/c_source_high_byte_escaper.sv @@
// Streams C source one byte per beat. Outside comments, in code and inside
// string literals, a byte with bit 7 set leaves as four beats: a backslash and
// three octal digits; every other byte leaves as one beat. rsp_last_of_run
// marks the final beat of each input byte. Plain bytes flow at one per cycle
// while rsp_ready is high, through the input register, then the result
// register; an escaped byte holds the result register until its last beat is
// taken, and the input side stalls meanwhile. Escaped quotes in strings are not
// recognized, and a high byte right after a slash in code is passed raw.
module c_source_high_byte_escaper
   import csbe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        res_valid_ff;
   logic [7:0]  res_byte_ff;
   logic        res_esc_ff;
   esc_pos_type res_pos_ff;
   logic        escape;
   logic        beat_done;
   logic        run_done;
   logic        res_free;
   logic        move;

   csbe_lexer u_lexer (
      .clock    (clock),
      .reset    (reset),
      .advance  (move),
      .lex_byte (in_byte_ff),
      .escape   (escape)
   );

   always_comb begin
      case (res_pos_ff)
         ESC_SLASH: rsp_out_byte = CHAR_BACKSLASH;
         ESC_HIGH:  rsp_out_byte = CHAR_ZERO + {6'd0, res_byte_ff[7:6]};
         ESC_MID:   rsp_out_byte = CHAR_ZERO + {5'd0, res_byte_ff[5:3]};
         ESC_LOW:   rsp_out_byte = CHAR_ZERO + {5'd0, res_byte_ff[2:0]};
         default:   rsp_out_byte = CHAR_BACKSLASH;
      endcase
      if (!res_esc_ff) begin
         rsp_out_byte = res_byte_ff;
      end
   end

   assign rsp_valid       = res_valid_ff;
   assign rsp_last_of_run = !res_esc_ff || (res_pos_ff == ESC_LOW);
   assign beat_done       = res_valid_ff && rsp_ready;
   assign run_done        = beat_done && rsp_last_of_run;
   assign res_free        = !res_valid_ff || run_done;
   assign move            = in_valid_ff && res_free;
   assign req_ready       = !in_valid_ff || move;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
         res_pos_ff   <= ESC_SLASH;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (move) begin
            res_valid_ff <= 1'b1;
            res_pos_ff   <= ESC_SLASH;
         end else if (run_done) begin
            res_valid_ff <= 1'b0;
         end else if (beat_done) begin
            res_pos_ff <= esc_pos_type'(res_pos_ff + 2'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_in_byte;
      end
      if (move) begin
         res_byte_ff <= in_byte_ff;
         res_esc_ff  <= escape;
      end
   end

endmodule

@@ sv/csbe_checker.sv @@
module csbe_checker
   import csbe_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_of_run
);

   // a stalled beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_last_of_run))
   else $error("rsp beat changed while stalled");

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
   else $error("rsp_valid high after reset");

   // inside an escape every beat but the last is a backslash or octal digit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |->
         rsp_out_byte == CHAR_BACKSLASH || rsp_out_byte[7:3] == CHAR_ZERO[7:3])
   else $error("bad byte inside escape");

   // escape beats follow each other with no gap
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid)
   else $error("gap inside escape run");

   // the beat after a backslash opener is the leading digit 2 or 3
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run && rsp_out_byte == CHAR_BACKSLASH
         |=> rsp_out_byte == 8'h32 || rsp_out_byte == 8'h33)
   else $error("bad leading octal digit");

endmodule

bind c_source_high_byte_escaper csbe_checker u_csbe_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_last_of_run (rsp_last_of_run)
);
